// ===== rtl/core/jbws_pkg.sv =====
// Package for the JPEG entropy bit writer with byte stuffing.
// Holds the port word types, the front-to-back command type and the function codes.
// No dependencies.
`default_nettype none

package jbws_pkg;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_FLUSH = 2'd1;
    localparam logic [1:0] FUNC_RAW   = 2'd2;

    localparam logic [7:0] STUFF_TRIGGER = 8'hFF;
    localparam logic [5:0] MAX_PUT_BITS  = 6'd32;
    localparam logic [3:0] BYTE_BITS     = 4'd8;

    // input word
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] bits_value;
        logic [5:0]  bit_count;
        logic [7:0]  raw_byte;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_word;

    // one queued job: up to four bytes, left aligned, first byte in [31:24]
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  nbytes;
        logic        stuff;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/jbws_front.sv =====
// Front part: accepts input words, packs put/flush bits against the pending store
// and turns each word that yields a byte into a byte job. Depends on jbws_pkg.
`default_nettype none

module jbws_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire jbws_pkg::t_in_word i_data,
    output logic                   o_stall,
    input  wire logic              i_full,
    output logic                   o_push,
    output jbws_pkg::t_cmd         o_cmd
);

    logic [6:0]  r_pend;
    logic [2:0]  r_pc;
    logic [6:0]  n_pend;
    logic [2:0]  n_pc;

    logic        accept;
    logic [5:0]  cnt;
    logic [31:0] value;
    logic [32:0] mask33;
    logic [39:0] word;
    logic [5:0]  total;
    logic [5:0]  align_sh;
    logic [39:0] aligned;
    logic [7:0]  pmask;
    logic        packs;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        cnt   = 6'd0;
        value = 32'd0;
        packs = 1'b0;
        case (i_data.func)
            jbws_pkg::FUNC_PUT: begin
                packs = 1'b1;
                cnt   = (i_data.bit_count > jbws_pkg::MAX_PUT_BITS) ?
                        jbws_pkg::MAX_PUT_BITS : i_data.bit_count;
                value = i_data.bits_value;
            end
            jbws_pkg::FUNC_FLUSH: begin
                // zero padding to the byte boundary, nothing if already aligned
                packs = (r_pc != 3'd0);
                cnt   = (r_pc != 3'd0) ? {2'd0, jbws_pkg::BYTE_BITS - {1'b0, r_pc}} : 6'd0;
            end
            default: begin
                packs = 1'b0;
            end
        endcase
    end

    always_comb begin
        mask33   = (33'd1 << cnt) - 33'd1;
        word     = ({33'd0, r_pend} << cnt) | {8'd0, value & mask33[31:0]};
        total    = {3'd0, r_pc} + cnt;
        align_sh = 6'd40 - total;
        aligned  = word << align_sh;
        pmask    = (8'd1 << total[2:0]) - 8'd1;
    end

    always_comb begin
        o_cmd  = '0;
        n_pend = r_pend;
        n_pc   = r_pc;
        if (packs) begin
            o_cmd.bytes  = aligned[39:8];
            o_cmd.nbytes = total[5:3];
            o_cmd.stuff  = 1'b1;
            n_pend       = word[6:0] & pmask[6:0];
            n_pc         = total[2:0];
        end else if (i_data.func == jbws_pkg::FUNC_RAW) begin
            o_cmd.bytes  = {i_data.raw_byte, 24'd0};
            o_cmd.nbytes = 3'd1;
            o_cmd.stuff  = 1'b0;
        end
    end

    assign o_push = accept && (o_cmd.nbytes != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 7'd0;
            r_pc   <= 3'd0;
        end else if (accept) begin
            r_pend <= n_pend;
            r_pc   <= n_pc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/jbws_fifo.sv =====
// Two-entry job queue between the front and back parts.
// Depends on jbws_pkg.
`default_nettype none

module jbws_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire jbws_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_head_valid,
    output jbws_pkg::t_cmd      o_head
);

    jbws_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           do_pop;

    assign o_full       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/jbws_back.sv =====
// Back part: takes byte jobs from the queue and, unless stalled, emits one byte
// a cycle, inserting 0x00 after 0xFF when stuffing is on. Depends on jbws_pkg.
`default_nettype none

module jbws_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire jbws_pkg::t_cmd i_head,
    output logic                o_pop,
    output logic                o_valid,
    output jbws_pkg::t_out_word o_data,
    input  wire logic           i_stall
);

    logic [31:0]         r_bytes;
    logic [2:0]          r_left;
    logic                r_stuff_en;
    logic                r_stuff_pend;
    logic                r_out_valid;
    jbws_pkg::t_out_word r_out;

    logic                busy;
    logic                slot_free;
    logic                need_stuff;
    logic [2:0]          left_n;

    assign busy       = (r_left != 3'd0) || r_stuff_pend;
    assign slot_free  = !r_out_valid || !i_stall;
    assign o_pop      = !busy && i_head_valid;
    assign need_stuff = r_stuff_en && (r_bytes[31:24] == jbws_pkg::STUFF_TRIGGER);
    assign left_n     = r_left - 3'd1;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= 3'd0;
            r_stuff_pend <= 1'b0;
            r_stuff_en   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_bytes      <= i_head.bytes;
                r_left       <= i_head.nbytes;
                r_stuff_en   <= i_head.stuff;
                r_stuff_pend <= 1'b0;
            end else if (slot_free && r_stuff_pend) begin
                // stuffed zero after 0xFF
                r_stuff_pend <= 1'b0;
            end else if (slot_free && busy) begin
                r_bytes      <= {r_bytes[23:0], 8'd0};
                r_left       <= left_n;
                r_stuff_pend <= need_stuff;
            end

            if (slot_free) begin
                r_out_valid <= busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && busy) begin
            if (r_stuff_pend) begin
                r_out.out_byte  <= 8'd0;
                r_out.last_byte <= (r_left == 3'd0);
            end else begin
                r_out.out_byte  <= r_bytes[31:24];
                r_out.last_byte <= !need_stuff && (left_n == 3'd0);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/jpeg_bit_writer_stuffing_top.sv =====
// JPEG entropy bit writer with byte stuffing, top level. Uses jbws_pkg, jbws_front,
// jbws_fifo and jbws_back.
// Path: a taken word's job is written into the queue, loaded into the back end and
// registered to o_valid. Throughput: one output byte per cycle unless i_stall is high;
// the byte-wide back end takes a job (up to 8 bytes with stuffing) once the last is out.
// Reset: synchronous, active low; clears pending bits, queue and output valid.
`default_nettype none

module jpeg_bit_writer_stuffing_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_valid,
    input  wire jbws_pkg::t_in_word  i_data,
    output logic                     o_stall,
    // output channel
    output logic                     o_valid,
    output jbws_pkg::t_out_word      o_data,
    input  wire logic                i_stall
);

    // front -> queue
    logic           push;
    jbws_pkg::t_cmd cmd;
    logic           full;
    // queue -> back
    logic           pop;
    logic           head_valid;
    jbws_pkg::t_cmd head;

    // Front owns the pending bit store and updates it as each word is taken;
    // output order is kept by the in-order queue, so the back may lag freely.
    jbws_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    // words that make no byte (short put, empty flush, unused code) never enter
    jbws_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // back end drives the output register; last_byte marks a job's final byte
    jbws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_data       (o_data),
        .i_stall      (i_stall)
    );

endmodule

`default_nettype wire
